@@ rtl/bad_pkg.sv @@
// ----------------------------------------------------------------------------
// bad_pkg
// Shared types and constants for the block average decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bad_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int FACT_W    = 8;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [FACT_W-1:0] FACTOR_RESET = FACT_W'(4);
    localparam logic [FACT_W-1:0] MAX_DECIM    = FACT_W'(255);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic acc;   // input word taken this cycle
        logic step;  // one divider iteration
        logic load;  // move quotient into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic blk_done;  // the word on the input completes a block
        logic div_last;  // final divider iteration in progress
        logic out_busy;  // output register full and held by the receiver
    } t_dp_sts;

    // factor zero acts as one; clamp to the supported maximum
    function automatic logic [FACT_W-1:0] eff_factor(input logic [FACT_W-1:0] f);
        logic [FACT_W-1:0] r;
        r = f;
        if (r == '0) begin
            r = FACT_W'(1);
        end
        if (r > MAX_DECIM) begin
            r = MAX_DECIM;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/block_average_decimator.sv @@
// ----------------------------------------------------------------------------
// block_average_decimator
// Boxcar average decimator: mean of every decim_factor samples.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one signed 16-bit sample per word.
// Output channel: o_valid / i_stall carry one signed 16-bit average per word.
// Config: i_cfg_we writes i_cfg_wdata into decim_factor (reset 4, 0 acts as 1).
// Samples that do not finish a block are taken one per cycle while no divide
// or hand-off is in progress. The sample that finishes a block starts a
// restoring divider that retires one quotient bit a cycle over the 24-bit sum
// magnitude; a hand-off state then signs and clamps the quotient and loads
// the output register. o_stall stays high from the completing sample until
// the result is loaded.
// The output register frees the input side: once the result is loaded, new
// samples are taken even while the receiver stalls. If a second block finishes
// before the first result drains, the hand-off waits with o_stall high until
// the output register empties. A held word never changes.
// Reset (synchronous, active low) clears the sum, the count, the output valid
// and sets the factor to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_decimator
    import bad_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [FACT_W-1:0]          i_cfg_wdata,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [SAMPLE_W-1:0]      o_average
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    bad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // accumulator, divider, output register
    bad_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_sample),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_average   (o_average),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

@@ rtl/bad_ctrl.sv @@
// ----------------------------------------------------------------------------
// bad_ctrl
// Sequencer: accept words, run the serial divide, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_ctrl
    import bad_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_sts.blk_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall   = 1'b0;
                o_cmd.acc = i_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_OUT: begin
                o_cmd.load = !i_sts.out_busy;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last) |=> (r_state == ST_OUT))
        else $error("divide did not end in hand-off");

    a_done_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.acc && i_sts.blk_done) |=> (r_state == ST_DIV))
        else $error("completed block did not start divide");

endmodule

`default_nettype wire

@@ rtl/bad_dp.sv @@
// ----------------------------------------------------------------------------
// bad_dp
// Accumulator, restoring serial divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_dp
    import bad_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [FACT_W-1:0]          i_cfg_wdata,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_stall,
    output logic                            o_valid,
    output logic signed [SAMPLE_W-1:0]      o_average,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_sts                         o_sts
);

    logic [FACT_W-1:0]        r_factor;
    logic signed [SUM_W-1:0]  r_sum;
    logic [FACT_W-1:0]        r_count;
    logic [SUM_W-1:0]         r_quo;
    logic [FACT_W-1:0]        r_rem;
    logic [FACT_W-1:0]        r_div;
    logic                     r_neg;
    logic [STEP_W-1:0]        r_step;
    logic                     r_o_valid;
    logic signed [SAMPLE_W-1:0] r_avg;

    logic [FACT_W-1:0]       f_eff;
    logic [FACT_W-1:0]       count_inc;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [SUM_W-1:0] sum_sat;
    logic [SUM_W-1:0]        sum_mag;
    logic [FACT_W:0]         trial;
    logic [FACT_W:0]         diff;
    logic                    ge;
    logic signed [SAMPLE_W-1:0] avg_sat;

    assign f_eff     = eff_factor(r_factor);
    assign count_inc = (r_count == '1) ? r_count : r_count + FACT_W'(1);

    // saturating add, one guard bit
    assign sum_ext = {r_sum[SUM_W-1], r_sum}
                   + {{(SUM_W+1-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end
    assign sum_mag = sum_sat[SUM_W-1] ? (~sum_sat + SUM_W'(1)) : sum_sat;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    // sign and clamp to 16 bits
    always_comb begin
        if (r_neg) begin
            if (r_quo > SUM_W'(32768)) begin
                avg_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end else begin
                avg_sat = SAMPLE_W'(~r_quo[SAMPLE_W-1:0] + SAMPLE_W'(1));
            end
        end else begin
            if (r_quo > SUM_W'(32767)) begin
                avg_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else begin
                avg_sat = r_quo[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor  <= FACTOR_RESET;
            r_sum     <= '0;
            r_count   <= '0;
            r_step    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_factor <= i_cfg_wdata;
            end
            if (i_cmd.acc) begin
                if (count_inc >= f_eff) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= sum_sat;
                    r_count <= count_inc;
                end
                r_step <= '0;
            end else if (i_cmd.step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && (count_inc >= f_eff)) begin
            r_quo <= sum_mag;
            r_rem <= '0;
            r_div <= f_eff;
            r_neg <= sum_sat[SUM_W-1];
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
        end
        if (i_cmd.load) begin
            r_avg <= avg_sat;
        end
    end

    assign o_sts.blk_done = (count_inc >= f_eff);
    assign o_sts.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_sts.out_busy = r_o_valid && i_stall;
    assign o_valid        = r_o_valid;
    assign o_average      = r_avg;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_block_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc && o_sts.blk_done) |=> (r_count == '0 && r_sum == '0))
        else $error("accumulator not cleared at block end");

endmodule

`default_nettype wire

@@ test/block_average_decimator_test.sv @@
// ----------------------------------------------------------------------------
// block_average_decimator_test
// Self-checking bench for the boxcar average decimator: a queue-fed driver
// offers samples, a clocked monitor predicts each block mean and compares
// every output word in order, over several decimation factors.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_decimator_test
    import bad_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
    localparam int SETTLE      = 30;      // divider plus output load, with margin
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int ACC_MAX     = 8388607;
    localparam int ACC_MIN     = -8388608;
    localparam int AVG_MAX     = 32767;
    localparam int AVG_MIN     = -32768;

    // DUT ports
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [FACT_W-1:0]          i_cfg_wdata = '0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic signed [SAMPLE_W-1:0] o_average;

    block_average_decimator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_average   (o_average)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] sample_q[$];       // words waiting for the driver
    logic signed [SAMPLE_W-1:0] avg_expected_q[$]; // predicted block means, oldest first

    int queued_count = 0;   // samples handed to the driver
    int taken_count  = 0;   // samples the DUT accepted
    int errors       = 0;
    int cycle_count  = 0;

    // Handshake flags, registered at the rising edge, used at the falling edge
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    // Idle shaping: per-phase upper bound of the per-word wait (0 = no gaps)
    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int tx_wait    = 0;
    int rx_wait    = 0;
    int rx_next    = 0;

    logic hold_start = 1'b0;
    logic rx_hold    = 1'b0;

    // Shadow of the decimator: factor register and running block
    logic [FACT_W-1:0] factor_reg = FACTOR_RESET;
    int                blk_sum    = 0;
    int                blk_count  = 0;

    // ------------------------------------------------------------------------
    // Predictor: fold one accepted sample into the shadow block. When the
    // count reaches the effective factor, queue the truncated mean.
    // ------------------------------------------------------------------------
    task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s);
        int f;
        int sum;
        int avg;
        f = int'(factor_reg);
        if (f == 0) begin
            f = 1;                      // zero acts as one
        end
        if (f > int'(MAX_DECIM)) begin
            f = int'(MAX_DECIM);
        end
        sum = blk_sum + int'(s);
        if (sum > ACC_MAX) begin
            sum = ACC_MAX;
        end
        if (sum < ACC_MIN) begin
            sum = ACC_MIN;
        end
        blk_sum = sum;
        if (blk_count < 255) begin
            blk_count++;
        end
        // >= covers a factor lowered below a partial block's count
        if (blk_count >= f) begin
            avg = blk_sum / f;          // truncates toward zero
            if (avg > AVG_MAX) begin
                avg = AVG_MAX;
            end
            if (avg < AVG_MIN) begin
                avg = AVG_MIN;
            end
            avg_expected_q.push_back(SAMPLE_W'(avg));
            blk_sum   = 0;
            blk_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: handshake capture, prediction, output check, timeout
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_valid && !o_stall;
            out_taken <= o_valid && !i_stall;
            if (i_valid && !o_stall) begin
                accumulate_sample(i_sample);
                taken_count <= taken_count + 1;
            end
            if (o_valid && !i_stall) begin
                if (avg_expected_q.size() == 0) begin
                    $display("%0t: unexpected average word: expected none, actual %0d",
                             $time, o_average);
                    errors++;
                end else if (o_average !== avg_expected_q[0]) begin
                    $display("%0t: average mismatch: expected %0d, actual %0d",
                             $time, avg_expected_q[0], o_average);
                    errors++;
                    void'(avg_expected_q.pop_front());
                end else begin
                    void'(avg_expected_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: falling edge. A word stays put until taken; then a drawn number
    // of idle cycles passes before the next one is offered.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // stalled: hold word
        end else if (tx_wait > 0) begin
            i_valid <= 1'b0;
            tx_wait <= tx_wait - 1;
        end else if (sample_q.size() != 0) begin
            i_sample <= sample_q.pop_front();
            i_valid  <= 1'b1;
            tx_wait  <= $urandom_range(0, tx_gap_max);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: falling edge. After each taken word, stall for a drawn number
    // of cycles; the long hold-off overrides.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_next = rx_wait;
        if (out_taken) begin
            rx_next = $urandom_range(0, rx_gap_max);
        end
        if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (rx_next > 0) begin
            i_stall <= 1'b1;
            rx_next--;
        end else begin
            i_stall <= 1'b0;
        end
        rx_wait = rx_next;
    end

    // Long hold-off, counted here so the sender keeps offering meanwhile
    initial begin
        wait (hold_start);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        sample_q.push_back(s);
        queued_count++;
    endtask

    // Full-range random with a fair share of the two extremes
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Sender drained and every predicted mean received, then let the
    // divider settle in case a block was still in flight
    task automatic wait_idle();
        while (taken_count != queued_count || avg_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_factor(input logic [FACT_W-1:0] f);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= f;
        factor_reg   = f;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [FACT_W-1:0] pick_factor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FACT_W'($urandom_range(9, 40));
            default: return FACT_W'($urandom_range(1, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int                         n;
        int                         rand_items;
        int                         bias;
        logic signed [SAMPLE_W-1:0] v;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset factor of 4: both rails, truncation toward zero
        repeat (4) push_sample(16'sh7FFF);
        repeat (4) push_sample(16'sh8000);
        push_sample(16'sd1);
        push_sample(-16'sd2);
        push_sample(16'sd0);
        push_sample(16'sd0);
        push_sample(-16'sd5);
        repeat (3) push_sample(16'sd0);
        push_sample(16'sd7);
        push_sample(16'sd3);
        push_sample(16'sd0);
        push_sample(-16'sd1);

        // Factor one: every sample passes straight through
        set_factor(FACT_W'(1));
        push_sample(16'sh5555);
        push_sample(16'shAAAA);

        // Factor zero behaves as one
        set_factor('0);
        push_sample(-16'sd1);
        push_sample(16'sd1);

        // Factor lowered mid-block: 5 of 8 counted, then factor 2; the next
        // sample closes the block and the mean clips at the positive rail
        set_factor(FACT_W'(8));
        repeat (5) push_sample(16'sh7FFF);
        set_factor(FACT_W'(2));
        push_sample(16'sh7FFF);

        // Pressure: receiver holds off while the sender streams without gaps,
        // so the output register fills and the input side stalls
        set_factor(FACT_W'(1));
        tx_gap_max = 0;
        rx_gap_max = 18;
        hold_start = 1'b1;
        repeat (40) push_sample(rand_sample());

        // Random phases on small factors; each ends wherever it ends, so the
        // next factor often lands on a partial block
        rand_items = 0;
        while (rand_items < 140) begin
            set_factor(pick_factor());
            tx_gap_max = $urandom_range(0, 1) ? 18 : 0;
            rx_gap_max = $urandom_range(0, 1) ? 18 : 0;
            n = $urandom_range(4, 30);
            repeat (n) push_sample(rand_sample());
            rand_items += n;
        end

        // Largest factor: one full block biased to one rail, then a long
        // partial block cut short by a smaller factor (mean clips)
        set_factor(MAX_DECIM);
        tx_gap_max = $urandom_range(0, 1) ? 18 : 0;
        rx_gap_max = 18;
        bias = $urandom_range(0, 1);
        repeat (300) begin
            if ($urandom_range(0, 3) != 0) begin
                v = bias ? 16'sh7FFF : 16'sh8000;
            end else begin
                v = rand_sample();
            end
            push_sample(v);
        end
        set_factor(FACT_W'(7));
        push_sample(bias ? 16'sh7FFF : 16'sh8000);

        // A few more short random phases, back from the wide factor
        rand_items = 0;
        while (rand_items < 40) begin
            set_factor(pick_factor());
            tx_gap_max = $urandom_range(0, 1) ? 18 : 0;
            rx_gap_max = $urandom_range(0, 1) ? 18 : 0;
            n = $urandom_range(4, 20);
            repeat (n) push_sample(rand_sample());
            rand_items += n;
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && avg_expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/bad_pkg.sv
rtl/bad_ctrl.sv
rtl/bad_dp.sv
rtl/block_average_decimator.sv
test/block_average_decimator_test.sv
